// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; included by the files that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/mbca_pkg.sv =====
// codes, field widths and the result record of the credit admission block
// no dependencies; used by the top level, its checker and the testbench
package mbca_pkg;

	localparam int STATUS_W = 3;
	localparam int WHO_W    = 2;
	localparam int OP_W     = 3;
	localparam int MSGS_W   = 32;
	localparam int BYTES_W  = 48;
	localparam int SIZE_W   = 32;
	localparam int TICKS_W  = 32;
	localparam int CFG_W    = 48;
	localparam int CFG_IDX_W = 2;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 88;

	localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
	localparam logic [OP_W-1:0] OP_OPEN    = 3'd2;
	localparam logic [OP_W-1:0] OP_CLOSE   = 3'd3;
	localparam logic [OP_W-1:0] OP_DRAIN   = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHUTDOWN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TIMED_OUT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_WAITING  = 3'd6;

	// who a result answers; also the kind of waiter in the slot
	localparam logic [WHO_W-1:0] WHO_ITEM    = 2'd0;
	localparam logic [WHO_W-1:0] WHO_ACQUIRE = 2'd1;
	localparam logic [WHO_W-1:0] WHO_DRAIN   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACQUIRE_WAIT  = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WHO_W-1:0]    answers_for;
		logic [MSGS_W-1:0]   messages_now;
		logic [BYTES_W-1:0]  bytes_now;
		logic                accepting_now;
		logic                last;
	} result_t;

endpackage

// ===== hw/rtl/message_byte_credit_admission.sv =====
// credit admission: message and byte counters, one wait slot, result queue
// depends on mbca_pkg
//
// Usage: requests enter on the s_ side (acquire, release, open, close,
// drain, one-millisecond tick) and results leave on the m_ side. Each request
// gives its own result, and may give a second one for the waiter in the slot
// (a blocked acquire or a waiting drain); tlast marks the final result of a
// request and tuser says whom a result answers. Limits, block mode and the
// acquire wait are written on the cfg_ port; the user must do so only while
// the block is idle, as the block itself does not enforce it. Results are
// registered in the result queue. Throughput: one request per cycle while
// results are taken; a request that also answers the waiter puts two results
// on the output. The rate is set by the counter update and the single output port.
// The result queue holds four entries and s_tready stays high while at least
// two are free, so a stalled receiver is absorbed for a few requests before
// the input side stalls. Nothing is lost or repeated under back-pressure.
// Reset: counters zero, admission closed, slot empty, all limits zero.
module message_byte_credit_admission #(
	parameter int COUNT_BITS = 32,
	parameter int TOTAL_BITS = 48,
	parameter int WAIT_BITS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// operation [2:0], byte_count [34:3], drain_wait_ticks [66:35], zero pad
	input  logic [mbca_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status [2:0], messages_now [34:3], bytes_now [82:35], accepting_now [83], zero pad
	output logic [mbca_pkg::OUT_DATA_W-1:0]  m_tdata,
	// answers_for [1:0]
	output logic [mbca_pkg::WHO_W-1:0]       m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_write,
	input  logic [mbca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbca_pkg::CFG_W-1:0]       cfg_data
);
	import mbca_pkg::*;

	localparam int SUM_W = ((TOTAL_BITS > BYTES_W) ? TOTAL_BITS : BYTES_W) + 1;
	localparam int CMP_W = (COUNT_BITS > MSGS_W) ? COUNT_BITS : MSGS_W;
	localparam int TCK_W = (WAIT_BITS > TICKS_W) ? WAIT_BITS : TICKS_W;

	logic [MSGS_W-1:0]     msg_limit_q;
	logic [BYTES_W-1:0]    byte_limit_q;
	logic                  block_mode_q;
	logic [TICKS_W-1:0]    acq_wait_q;

	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [TOTAL_BITS-1:0] total_q, total_d;
	logic                  accepting_q, accepting_d;
	logic [WHO_W-1:0]      wkind_q, wkind_d;
	logic [SIZE_W-1:0]     wbytes_q, wbytes_d;
	logic [WAIT_BITS-1:0]  wcd_q, wcd_d;
	logic                  wforever_q, wforever_d;

	logic [OP_W-1:0]       op;
	logic [SIZE_W-1:0]     size;
	logic [TICKS_W-1:0]    dwait;
	logic                  accept;
	logic [STATUS_W-1:0]   st, wst;
	logic [WHO_W-1:0]      wwho;
	logic                  wres;
	logic [COUNT_BITS-1:0] rel_count;
	logic [TOTAL_BITS-1:0] rel_total;
	logic [WAIT_BITS-1:0]  cd_dec;
	result_t               res0, res1;

	result_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_q, rd_q;
	logic [QPTR_W:0]       occ_q;
	logic                  pop;

	function automatic logic room_for(input logic [COUNT_BITS-1:0] cnt,
			input logic [TOTAL_BITS-1:0] tot, input logic [SIZE_W-1:0] b);
		logic [SUM_W-1:0] sum;
		logic             ok;
		begin
			sum = SUM_W'(tot) + SUM_W'(b);
			ok = 1'b1;
			if (&cnt)
				ok = 1'b0;
			if (sum > SUM_W'({TOTAL_BITS{1'b1}}))
				ok = 1'b0;
			if (msg_limit_q != '0 && CMP_W'(cnt) >= CMP_W'(msg_limit_q))
				ok = 1'b0;
			if (byte_limit_q != '0 && sum > SUM_W'(byte_limit_q))
				ok = 1'b0;
			room_for = ok;
		end
	endfunction

	// wait length into the slot, saturating at the countdown width
	function automatic logic [WAIT_BITS-1:0] sat_ticks(input logic [TICKS_W-1:0] t);
		begin
			if (TCK_W'(t) > TCK_W'({WAIT_BITS{1'b1}}))
				sat_ticks = '1;
			else
				sat_ticks = WAIT_BITS'(t);
		end
	endfunction

	assign op     = s_tdata[OP_W-1:0];
	assign size   = s_tdata[OP_W +: SIZE_W];
	assign dwait  = s_tdata[OP_W+SIZE_W +: TICKS_W];
	assign accept = s_tvalid && s_tready;

	assign rel_count = count_q - 1'b1;
	assign rel_total = total_q - TOTAL_BITS'(size);
	assign cd_dec    = (wcd_q != '0) ? wcd_q - 1'b1 : '0;

	always_comb begin
		count_d     = count_q;
		total_d     = total_q;
		accepting_d = accepting_q;
		wkind_d     = wkind_q;
		wbytes_d    = wbytes_q;
		wcd_d       = wcd_q;
		wforever_d  = wforever_q;
		st          = ST_OK;
		wst         = ST_OK;
		wwho        = WHO_ITEM;
		wres        = 1'b0;
		case (op)
			OP_ACQUIRE: begin
				if (byte_limit_q != '0 && BYTES_W'(size) > byte_limit_q) begin
					st = ST_NO_SPACE;
				end else if (!accepting_q) begin
					st = ST_SHUTDOWN;
				end else if (room_for(count_q, total_q, size)) begin
					count_d = count_q + 1'b1;
					total_d = total_q + TOTAL_BITS'(size);
				end else if (!block_mode_q) begin
					st = ST_NO_SPACE;
				end else if (wkind_q != WHO_ITEM) begin
					st = ST_BUSY;
				end else if (acq_wait_q == '0) begin
					st = ST_TIMED_OUT;
				end else begin
					wkind_d    = WHO_ACQUIRE;
					wbytes_d   = size;
					wforever_d = &acq_wait_q;
					wcd_d      = sat_ticks(acq_wait_q);
					st         = ST_WAITING;
				end
			end
			OP_RELEASE: begin
				if (count_q == '0 || SUM_W'(total_q) < SUM_W'(size)) begin
					st = ST_RANGE;
				end else begin
					count_d = rel_count;
					total_d = rel_total;
					// the slot is re-checked against the counts after the release
					if (wkind_q == WHO_ACQUIRE) begin
						if (!accepting_q) begin
							wres    = 1'b1;
							wst     = ST_SHUTDOWN;
							wwho    = WHO_ACQUIRE;
							wkind_d = WHO_ITEM;
						end else if (room_for(rel_count, rel_total, wbytes_q)) begin
							count_d = rel_count + 1'b1;
							total_d = rel_total + TOTAL_BITS'(wbytes_q);
							wres    = 1'b1;
							wst     = ST_OK;
							wwho    = WHO_ACQUIRE;
							wkind_d = WHO_ITEM;
						end
					end else if (wkind_q == WHO_DRAIN && rel_count == '0) begin
						wres    = 1'b1;
						wst     = ST_OK;
						wwho    = WHO_DRAIN;
						wkind_d = WHO_ITEM;
					end
				end
			end
			OP_OPEN: begin
				if (count_q != '0 || total_q != '0)
					st = ST_BUSY;
				else
					accepting_d = 1'b1;
			end
			OP_CLOSE: begin
				accepting_d = 1'b0;
				if (wkind_q == WHO_ACQUIRE) begin
					wres    = 1'b1;
					wst     = ST_SHUTDOWN;
					wwho    = WHO_ACQUIRE;
					wkind_d = WHO_ITEM;
				end
			end
			OP_DRAIN: begin
				if (count_q == '0) begin
					st = ST_OK;
				end else if (dwait == '0) begin
					st = ST_TIMED_OUT;
				end else if (wkind_q != WHO_ITEM) begin
					st = ST_BUSY;
				end else begin
					wkind_d    = WHO_DRAIN;
					wbytes_d   = '0;
					wforever_d = &dwait;
					wcd_d      = sat_ticks(dwait);
					st         = ST_WAITING;
				end
			end
			OP_TICK: begin
				if (wkind_q != WHO_ITEM && !wforever_q) begin
					wcd_d = cd_dec;
					if (cd_dec == '0) begin
						wres    = 1'b1;
						wst     = ST_TIMED_OUT;
						wwho    = wkind_q;
						wkind_d = WHO_ITEM;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res0.status        = st;
		res0.answers_for   = WHO_ITEM;
		res0.messages_now  = MSGS_W'(count_d);
		res0.bytes_now     = BYTES_W'(total_d);
		res0.accepting_now = accepting_d;
		res0.last          = !wres;
		res1               = res0;
		res1.status        = wst;
		res1.answers_for   = wwho;
		res1.last          = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_limit_q  <= '0;
			byte_limit_q <= '0;
			block_mode_q <= 1'b0;
			acq_wait_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MESSAGE_LIMIT: msg_limit_q  <= cfg_data[MSGS_W-1:0];
				CFG_BYTE_LIMIT:    byte_limit_q <= cfg_data[BYTES_W-1:0];
				CFG_BLOCK_MODE:    block_mode_q <= cfg_data[0];
				CFG_ACQUIRE_WAIT:  acq_wait_q   <= cfg_data[TICKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			accepting_q <= 1'b0;
			wkind_q     <= WHO_ITEM;
			wbytes_q    <= '0;
			wcd_q       <= '0;
			wforever_q  <= 1'b0;
		end else if (accept) begin
			count_q     <= count_d;
			total_q     <= total_d;
			accepting_q <= accepting_d;
			wkind_q     <= wkind_d;
			wbytes_q    <= wbytes_d;
			wcd_q       <= wcd_d;
			wforever_q  <= wforever_d;
		end
	end

	// result queue: one or two entries pushed per request, one popped per cycle while m_tready is high
	assign pop      = m_tvalid && m_tready;
	assign s_tready = occ_q <= (QPTR_W+1)'(QUEUE_DEPTH - 2);
	assign m_tvalid = occ_q != '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wr_q] <= res0;
			if (wres)
				queue_q[wr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
		end else begin
			if (accept)
				wr_q <= wr_q + (wres ? QPTR_W'(2) : QPTR_W'(1));
			if (pop)
				rd_q <= rd_q + 1'b1;
			occ_q <= occ_q + (accept ? (wres ? (QPTR_W+1)'(2) : (QPTR_W+1)'(1)) : '0)
				- (pop ? (QPTR_W+1)'(1) : '0);
		end
	end

	assign m_tdata = {4'b0, queue_q[rd_q].accepting_now, queue_q[rd_q].bytes_now,
		queue_q[rd_q].messages_now, queue_q[rd_q].status};
	assign m_tuser = queue_q[rd_q].answers_for;
	assign m_tlast = queue_q[rd_q].last;

endmodule

// ===== hw/rtl/mbca_checker.sv =====
// port-level checks on the result channel of the credit admission block
// depends on mbca_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module mbca_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mbca_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [mbca_pkg::WHO_W-1:0]      m_tuser,
	input logic                            m_tlast
);
	import mbca_pkg::*;

	logic [STATUS_W-1:0] status;

	assign status = m_tdata[STATUS_W-1:0];

	`ASSERT_NEXT(a_valid_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_data_holds, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// a waiter's answer is always the final result of its request
	`ASSERT_NOW(a_waiter_last, clk, arst_n, m_tvalid && m_tuser != WHO_ITEM, m_tlast)
	// a waiter is only ever released with ok, shutdown or timed out
	`ASSERT_NOW(a_waiter_status, clk, arst_n, m_tvalid && m_tuser != WHO_ITEM,
		status == ST_OK || status == ST_SHUTDOWN || status == ST_TIMED_OUT)

endmodule

bind message_byte_credit_admission mbca_checker u_mbca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== tb/message_byte_credit_admission_tb.sv =====
`timescale 1ns / 100ps
// testbench for the message and byte credit admission block
// directed then random requests, results checked against a scoreboard; depends on mbca_pkg
module message_byte_credit_admission_tb;
	import mbca_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 285;
	localparam bit [31:0] WAIT_FOREVER = 32'hFFFF_FFFF;
	localparam bit [63:0] TOTAL_MAX = 64'h0000_FFFF_FFFF_FFFF;
	localparam bit [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam bit [OP_W-1:0] OP_SPARE_B = 3'd7;

	typedef struct packed {
		bit [OP_W-1:0]    op;
		bit [SIZE_W-1:0]  size;
		bit [TICKS_W-1:0] dwait;
	} request_t;

	class admission_scoreboard;
		bit [MSGS_W-1:0]  message_limit;
		bit [BYTES_W-1:0] byte_limit;
		bit               block_mode;
		bit [TICKS_W-1:0] acquire_wait;
		bit [MSGS_W-1:0]  in_flight;
		bit [BYTES_W-1:0] bytes_held;
		bit               accepting;
		bit [WHO_W-1:0]   slot_kind;
		bit [SIZE_W-1:0]  slot_bytes;
		bit [TICKS_W-1:0] slot_ticks;
		bit               slot_forever;
		result_t          pending_results[$];
		bit [SIZE_W-1:0]  held_sizes[$];
		int mismatches;
		int unexpected;
		int requests;
		int results;
		int slot_answers;

		function new();
			mismatches = 0;
			unexpected = 0;
			requests = 0;
			results = 0;
			slot_answers = 0;
		endfunction

		function void set_register(bit [CFG_IDX_W-1:0] index, bit [CFG_W-1:0] value);
			case (index)
				CFG_MESSAGE_LIMIT: message_limit = value[MSGS_W-1:0];
				CFG_BYTE_LIMIT:    byte_limit = value[BYTES_W-1:0];
				CFG_BLOCK_MODE:    block_mode = value[0];
				CFG_ACQUIRE_WAIT:  acquire_wait = value[TICKS_W-1:0];
				default: ;
			endcase
		endfunction

		// counters never wrap: a full message count or byte total means no room
		function bit has_room(bit [SIZE_W-1:0] size);
			bit [63:0] b;
			bit [63:0] total;
			bit [63:0] blim;
			b = 64'(size);
			total = 64'(bytes_held);
			blim = 64'(byte_limit);
			if (in_flight == '1) return 1'b0;
			if (total > TOTAL_MAX - b) return 1'b0;
			if (message_limit != 0 && in_flight >= message_limit) return 1'b0;
			if (byte_limit != 0 && (total > blim || b > blim - total)) return 1'b0;
			return 1'b1;
		endfunction

		function void admit(bit [SIZE_W-1:0] size);
			in_flight = in_flight + 1;
			bytes_held = bytes_held + BYTES_W'(size);
			held_sizes.push_back(size);
		endfunction

		function void clear_slot();
			slot_kind = WHO_ITEM;
			slot_bytes = '0;
			slot_ticks = '0;
			slot_forever = 1'b0;
		endfunction

		function void fill_slot(bit [WHO_W-1:0] kind, bit [SIZE_W-1:0] size,
				bit [TICKS_W-1:0] ticks);
			slot_kind = kind;
			slot_bytes = size;
			slot_forever = (ticks == WAIT_FOREVER);
			slot_ticks = ticks;
		endfunction

		function result_t snapshot(bit [STATUS_W-1:0] status, bit [WHO_W-1:0] who);
			result_t r;
			r.status = status;
			r.answers_for = who;
			r.messages_now = in_flight;
			r.bytes_now = bytes_held;
			r.accepting_now = accepting;
			r.last = 1'b0;
			return r;
		endfunction

		function void note_request(bit [OP_W-1:0] op, bit [SIZE_W-1:0] size,
				bit [TICKS_W-1:0] dwait);
			result_t own;
			result_t extra;
			bit [STATUS_W-1:0] st;
			bit [STATUS_W-1:0] extra_status;
			bit [WHO_W-1:0] extra_who;
			bit has_extra;
			int idx;
			st = ST_OK;
			extra_status = ST_OK;
			extra_who = WHO_ITEM;
			has_extra = 1'b0;
			requests++;
			case (op)
				OP_ACQUIRE: begin
					if (byte_limit != 0 && {16'd0, size} > byte_limit) st = ST_NO_SPACE;
					else if (!accepting) st = ST_SHUTDOWN;
					else if (has_room(size)) admit(size);
					else if (!block_mode) st = ST_NO_SPACE;
					else if (slot_kind != WHO_ITEM) st = ST_BUSY;
					else if (acquire_wait == 0) st = ST_TIMED_OUT;
					else begin
						fill_slot(WHO_ACQUIRE, size, acquire_wait);
						st = ST_WAITING;
					end
				end
				OP_RELEASE: begin
					if (in_flight == 0 || bytes_held < BYTES_W'(size)) begin
						st = ST_RANGE;
					end else begin
						in_flight = in_flight - 1;
						bytes_held = bytes_held - BYTES_W'(size);
						// keep the list of held sizes roughly in step for the stimulus
						idx = -1;
						foreach (held_sizes[i]) if (idx < 0 && held_sizes[i] == size) idx = i;
						if (idx >= 0) held_sizes.delete(idx);
						else if (held_sizes.size() != 0) void'(held_sizes.pop_front());
						if (slot_kind == WHO_ACQUIRE) begin
							if (!accepting) begin
								has_extra = 1'b1;
								extra_status = ST_SHUTDOWN;
								extra_who = WHO_ACQUIRE;
								clear_slot();
							end else if (has_room(slot_bytes)) begin
								admit(slot_bytes);
								has_extra = 1'b1;
								extra_status = ST_OK;
								extra_who = WHO_ACQUIRE;
								clear_slot();
							end
						end else if (slot_kind == WHO_DRAIN && in_flight == 0) begin
							has_extra = 1'b1;
							extra_status = ST_OK;
							extra_who = WHO_DRAIN;
							clear_slot();
						end
					end
				end
				OP_OPEN: begin
					if (in_flight != 0 || bytes_held != 0) st = ST_BUSY;
					else accepting = 1'b1;
				end
				OP_CLOSE: begin
					accepting = 1'b0;
					if (slot_kind == WHO_ACQUIRE) begin
						has_extra = 1'b1;
						extra_status = ST_SHUTDOWN;
						extra_who = WHO_ACQUIRE;
						clear_slot();
					end
				end
				OP_DRAIN: begin
					if (in_flight == 0) st = ST_OK;
					else if (dwait == 0) st = ST_TIMED_OUT;
					else if (slot_kind != WHO_ITEM) st = ST_BUSY;
					else begin
						fill_slot(WHO_DRAIN, '0, dwait);
						st = ST_WAITING;
					end
				end
				OP_TICK: begin
					if (slot_kind != WHO_ITEM && !slot_forever) begin
						if (slot_ticks > 0) slot_ticks = slot_ticks - 1;
						if (slot_ticks == 0) begin
							has_extra = 1'b1;
							extra_status = ST_TIMED_OUT;
							extra_who = slot_kind;
							clear_slot();
						end
					end
				end
				default: ;
			endcase
			own = snapshot(st, WHO_ITEM);
			if (has_extra) begin
				extra = snapshot(extra_status, extra_who);
				extra.last = 1'b1;
				pending_results.push_back(own);
				pending_results.push_back(extra);
			end else begin
				own.last = 1'b1;
				pending_results.push_back(own);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			results++;
			if (got.answers_for != WHO_ITEM) slot_answers++;
			if (pending_results.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("%0t: result with nothing expected: status %0d for %0d msgs %0d",
						$realtime, got.status, got.answers_for, got.messages_now);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.answers_for !== want.answers_for ||
					got.messages_now !== want.messages_now || got.bytes_now !== want.bytes_now ||
					got.accepting_now !== want.accepting_now || got.last !== want.last) begin
				mismatches++;
				if (mismatches + unexpected <= 10) begin
					$display("%0t: mismatch (expected / actual)", $realtime);
					$display("  status %0d / %0d  for %0d / %0d  last %0d / %0d  accepting %0d / %0d",
						want.status, got.status, want.answers_for, got.answers_for,
						want.last, got.last, want.accepting_now, got.accepting_now);
					$display("  messages %0d / %0d  bytes %0d / %0d", want.messages_now,
						got.messages_now, want.bytes_now, got.bytes_now);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [WHO_W-1:0]      m_tuser;
	logic                  m_tlast;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	admission_scoreboard sb = new();
	int cycle_count = 0;
	int settings_used = 0;
	int size_cap = 200;

	message_byte_credit_admission i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				sb.pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_request(input bit [OP_W-1:0] op, input bit [SIZE_W-1:0] size,
			input bit [TICKS_W-1:0] dwait);
		s_tdata <= {5'd0, dwait, size, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, size, dwait);
	endtask

	// registers change only with no result outstanding
	task automatic set_registers(input bit [MSGS_W-1:0] msg_lim, input bit [BYTES_W-1:0] byte_lim,
			input bit blk, input bit [TICKS_W-1:0] acq_wait);
		bit [CFG_IDX_W-1:0] regs [4];
		bit [CFG_W-1:0] values [4];
		int i;
		regs[0] = CFG_MESSAGE_LIMIT;
		regs[1] = CFG_BYTE_LIMIT;
		regs[2] = CFG_BLOCK_MODE;
		regs[3] = CFG_ACQUIRE_WAIT;
		values[0] = {16'd0, msg_lim};
		values[1] = byte_lim;
		values[2] = {47'd0, blk};
		values[3] = {16'd0, acq_wait};
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		for (i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= values[i];
			@(posedge clk);
			sb.set_register(regs[i], values[i]);
		end
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// mostly well-formed traffic: releases reuse sizes that are held
	function automatic request_t random_request();
		request_t r;
		int pick;
		int held;
		r.op = OP_TICK;
		r.size = $urandom;
		r.dwait = $urandom;
		held = sb.held_sizes.size();
		pick = $urandom_range(0, 99);
		if (!sb.accepting && pick < 40) begin
			r.op = (sb.in_flight == 0) ? OP_OPEN : OP_RELEASE;
			pick = 100;
		end
		if (pick < 38) begin
			r.op = OP_ACQUIRE;
			pick = $urandom_range(0, 99);
			if (pick < 70) r.size = $urandom_range(0, size_cap);
			else if (pick < 85) r.size = $urandom;
			else if (pick < 90) r.size = '1;
			else r.size = $urandom_range(0, 3);
		end else if (pick < 68 || (pick == 100 && r.op == OP_RELEASE)) begin
			r.op = OP_RELEASE;
			if (held != 0 && $urandom_range(0, 9) != 0)
				r.size = sb.held_sizes[$urandom_range(0, held - 1)];
			else if ($urandom_range(0, 1) == 0)
				r.size = $urandom_range(0, 8);
		end else if (pick < 82) begin
			r.op = OP_TICK;
		end else if (pick < 89) begin
			r.op = OP_DRAIN;
			pick = $urandom_range(0, 99);
			if (pick < 60) r.dwait = $urandom_range(1, 6);
			else if (pick < 75) r.dwait = '0;
			else if (pick < 90) r.dwait = WAIT_FOREVER;
		end else if (pick < 92) begin
			r.op = OP_CLOSE;
		end else if (pick < 97 || pick == 100) begin
			r.op = OP_OPEN;
		end else begin
			r.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
		end
		return r;
	endfunction

	initial begin : stimulus
		request_t r;
		int phase;
		int sent;
		int burst;
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// closed after reset, spare codes, release with nothing held
		send_request(OP_ACQUIRE, 32'd5, 32'd0);
		send_request(OP_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_SPARE_B, 32'd0, 32'd0);
		send_request(OP_RELEASE, 32'd0, 32'd0);
		send_request(OP_OPEN, 32'd0, 32'd0);
		send_request(OP_ACQUIRE, 32'd0, 32'd0);
		send_request(OP_ACQUIRE, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_RELEASE, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_RELEASE, 32'd1, 32'd0);
		send_request(OP_OPEN, 32'd0, 32'd0);
		// drain: no wait, counted wait, second waiter, forever across a close
		send_request(OP_DRAIN, 32'd0, 32'd0);
		send_request(OP_DRAIN, 32'd0, 32'd2);
		send_request(OP_DRAIN, 32'd0, 32'd5);
		send_request(OP_TICK, 32'd0, 32'd0);
		send_request(OP_TICK, 32'd0, 32'd0);
		send_request(OP_DRAIN, 32'd0, WAIT_FOREVER);
		send_request(OP_TICK, 32'd0, 32'd0);
		send_request(OP_CLOSE, 32'd0, 32'd0);
		send_request(OP_ACQUIRE, 32'd1, 32'd0);
		send_request(OP_RELEASE, 32'd0, 32'd0);
		send_request(OP_OPEN, 32'd0, 32'd0);

		// blocked acquire: oversized, wake on release, timeout, failed by close
		set_registers(32'd1, 48'd100, 1'b1, 32'd2);
		send_request(OP_ACQUIRE, 32'd101, 32'd0);
		send_request(OP_ACQUIRE, 32'd100, 32'd0);
		send_request(OP_ACQUIRE, 32'd7, 32'd0);
		send_request(OP_ACQUIRE, 32'd3, 32'd0);
		send_request(OP_DRAIN, 32'd0, 32'd3);
		send_request(OP_RELEASE, 32'd100, 32'd0);
		send_request(OP_ACQUIRE, 32'd8, 32'd0);
		send_request(OP_TICK, 32'd0, 32'd0);
		send_request(OP_TICK, 32'd0, 32'd0);
		send_request(OP_ACQUIRE, 32'd9, 32'd0);
		send_request(OP_CLOSE, 32'd0, 32'd0);
		send_request(OP_RELEASE, 32'd7, 32'd0);
		send_request(OP_OPEN, 32'd0, 32'd0);

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin set_registers('0, '0, 1'b0, '0); size_cap = 200; end
				1: begin set_registers(32'd4, 48'd1000, 1'b1, 32'd3); size_cap = 300; end
				2: begin set_registers(32'd1, '0, 1'b1, WAIT_FOREVER); size_cap = 50; end
				3: begin set_registers('0, '1, 1'b0, $urandom); size_cap = 1000; end
				4: begin set_registers('1, 48'd64, 1'b1, '0); size_cap = 40; end
				default: begin
					set_registers(MSGS_W'($urandom_range(1, 8)),
						BYTES_W'($urandom_range(16, 512)), 1'b1,
						TICKS_W'($urandom_range(1, 6)));
					size_cap = 128;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (k = 0; k < burst; k++) begin
					r = random_request();
					send_request(r.op, r.size, r.dwait);
					sent++;
				end
				if ($urandom_range(0, 3) != 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("ran %0d requests under %0d register settings; %0d results checked, %0d for the waiter",
			sb.requests, settings_used + 1, sb.results, sb.slot_answers);
		$display("mismatches %0d, unexpected results %0d, results never seen %0d",
			sb.mismatches, sb.unexpected, sb.pending_results.size());
		if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : result_sink
		result_t got;
		int rx_cycle;
		int seg_left;
		int mode;
		int hold;
		rx_cycle = 0;
		seg_left = 0;
		mode = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.messages_now = m_tdata[34:3];
				got.bytes_now = m_tdata[82:35];
				got.accepting_now = m_tdata[83];
				got.answers_for = m_tuser;
				got.last = m_tlast;
				sb.check_result(got);
			end
			rx_cycle++;
			// long hold-offs so the result queue fills and the input stalls
			if (rx_cycle == 1500 || rx_cycle == 4200) hold = 300;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= ($urandom_range(0, 7) != 0);
					default: m_tready <= (rx_cycle % 3 == 0);
				endcase
			end
		end
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mbca_pkg.sv
hw/rtl/message_byte_credit_admission.sv
hw/rtl/mbca_checker.sv
tb/message_byte_credit_admission_tb.sv
